/* sv/pip_pkg.sv */
// Package: word types, action codes, controller states and command/status structs.
package pip_pkg;

    localparam int CW = 24;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef struct packed {
        t_action            action;
        logic signed [CW-1:0] coord_x;
        logic signed [CW-1:0] coord_y;
        logic               count_boundary;
    } t_in_word;

    typedef struct packed {
        logic inside_res;
        logic on_edge;
        logic overflowed;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic append;
        logic clear;
        logic q_start;
        logic rd_first;
        logic rd_next;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    empty;
        logic    rd_last;
        logic    busy;
        logic    out_free;
    } t_dp_stat;

endpackage

/* sv/pip_ctrl.sv */
// Controller: sequences append, clear and query words through the datapath.
module pip_ctrl import pip_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.action)
                    ACT_APPEND: begin
                        o_cmd.append = 1'b1;
                        n_state      = ST_IDLE;
                    end
                    ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                    ACT_QUERY: begin
                        o_cmd.q_start = 1'b1;
                        if (i_stat.empty) begin
                            n_state = ST_FINISH;
                        end else begin
                            o_cmd.rd_first = 1'b1;
                            n_state        = ST_SCAN;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                o_cmd.rd_next = 1'b1;
                if (i_stat.rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/pip_datapath.sv */
// Datapath: vertex store, edge pipeline (difference, product, sign) and output register.
module pip_datapath import pip_pkg::*; #(
    parameter int MAX_VERTICES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  t_in_word  i_in_word,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * CW + 2;
    localparam int SW    = 2 * CW + 3;

    // captured word
    logic signed [CW-1:0] r_px, r_py;
    logic                 r_bnd;
    t_action              r_action;

    // store
    logic signed [CW-1:0] r_mem_x [MAX_VERTICES];
    logic signed [CW-1:0] r_mem_y [MAX_VERTICES];
    logic [CNT_W-1:0]     r_count;
    logic                 r_ovf;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        n_last_addr;
    logic [AW-1:0]        n_rd_addr;
    logic                 n_rd_en;
    logic                 n_full;

    // read stage
    logic signed [CW-1:0] r_rd_x, r_rd_y;
    logic                 r_rd_vld, r_rd_first;
    logic signed [CW-1:0] r_prev_x, r_prev_y;

    // difference stage
    logic signed [DW-1:0] n_da, n_db, n_dc, n_dd;
    logic signed [DW-1:0] r_da, r_db, r_dc, r_dd;
    logic                 n_strad, n_inbox;
    logic                 r_strad, r_inbox, r_d_vld;

    // product stage
    logic signed [PW-1:0] n_p1, n_p2;
    logic signed [PW-1:0] r_p1, r_p2;
    logic                 r_m_strad, r_m_inbox, r_m_dypos, r_m_dyneg, r_m_vld;

    // sign and accumulate
    logic signed [SW-1:0] n_diff;
    logic                 n_pos, n_neg, n_zero;
    logic                 r_parity, r_edge;

    // output
    logic                 r_out_vld;
    t_out_word            r_out_word;

    assign n_last_addr = AW'(r_count - CNT_W'(1));
    assign n_rd_addr   = i_cmd.rd_first ? n_last_addr : r_idx;
    assign n_rd_en     = i_cmd.rd_first | i_cmd.rd_next;
    assign n_full      = (r_count >= CNT_W'(MAX_VERTICES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px     <= i_in_word.coord_x;
            r_py     <= i_in_word.coord_y;
            r_bnd    <= i_in_word.count_boundary;
            r_action <= i_in_word.action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !n_full) begin
            r_mem_x[r_count[AW-1:0]] <= r_px;
            r_mem_y[r_count[AW-1:0]] <= r_py;
        end
        if (n_rd_en) begin
            r_rd_x <= r_mem_x[n_rd_addr];
            r_rd_y <= r_mem_y[n_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_d_vld    <= 1'b0;
            r_m_vld    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.append) begin
                if (n_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.rd_first) begin
                r_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_idx <= r_idx + AW'(1);
            end
            r_rd_vld   <= n_rd_en;
            r_rd_first <= i_cmd.rd_first;
            r_d_vld    <= r_rd_vld & ~r_rd_first;
            r_m_vld    <= r_d_vld;
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // edge from current vertex i to previous vertex j
    always_comb begin
        n_da    = DW'(r_prev_x) - DW'(r_rd_x);
        n_db    = DW'(r_py) - DW'(r_rd_y);
        n_dc    = DW'(r_px) - DW'(r_rd_x);
        n_dd    = DW'(r_prev_y) - DW'(r_rd_y);
        n_strad = (r_rd_y > r_py) != (r_prev_y > r_py);
        n_inbox = (((r_rd_x <= r_px) && (r_px <= r_prev_x)) ||
                   ((r_prev_x <= r_px) && (r_px <= r_rd_x))) &&
                  (((r_rd_y <= r_py) && (r_py <= r_prev_y)) ||
                   ((r_prev_y <= r_py) && (r_py <= r_rd_y)));
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prev_x <= r_rd_x;
            r_prev_y <= r_rd_y;
            r_da     <= n_da;
            r_db     <= n_db;
            r_dc     <= n_dc;
            r_dd     <= n_dd;
            r_strad  <= n_strad;
            r_inbox  <= n_inbox;
        end
    end

    assign n_p1 = PW'(r_da) * PW'(r_db);
    assign n_p2 = PW'(r_dc) * PW'(r_dd);

    always_ff @(posedge i_clk) begin
        if (r_d_vld) begin
            r_p1      <= n_p1;
            r_p2      <= n_p2;
            r_m_strad <= r_strad;
            r_m_inbox <= r_inbox;
            r_m_dypos <= !r_dd[DW-1] && (r_dd != '0);
            r_m_dyneg <= r_dd[DW-1];
        end
    end

    always_comb begin
        n_diff = SW'(r_p1) - SW'(r_p2);
        n_neg  = n_diff[SW-1];
        n_zero = (n_diff == '0);
        n_pos  = !n_neg && !n_zero;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_parity <= 1'b0;
            r_edge   <= 1'b0;
        end else if (r_m_vld) begin
            if (r_m_strad && ((r_m_dypos && n_pos) || (r_m_dyneg && n_neg))) begin
                r_parity <= ~r_parity;
            end
            if (r_bnd && n_zero && r_m_inbox) begin
                r_edge <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_word.inside_res <= r_edge | r_parity;
            r_out_word.on_edge    <= r_edge;
            r_out_word.overflowed <= r_ovf;
        end
    end

    assign o_stat.action   = r_action;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.rd_last  = (r_idx == n_last_addr);
    assign o_stat.busy     = r_rd_vld | r_d_vld | r_m_vld;
    assign o_stat.out_free = !r_out_vld || !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

/* sv/point_in_polygon_test_top.sv */
// Top level: point-in-polygon test with a vertex store and even-odd ray cast.
//
// Input channel (i_in_valid / o_in_stall / i_in_word): one word per action.
// An append stores a vertex (dropped and flagged as overflow when the store
// holds MAX_VERTICES), a clear empties the store and the overflow flag, a
// query gives one output word. Action code 3 is ignored.
// Output channel (o_out_valid / i_out_stall / o_out_word): one word per query
// carrying inside, on-edge and the sticky overflow flag.
// A query reads the last stored vertex, then each stored vertex in turn, and
// feeds them through a three-stage edge pipeline (difference, 25x25
// products, sign) that drains before the answer is registered. An empty
// store answers without any store read.
// Words are handled one at a time; o_in_stall is high while one is in work.
// The output register holds a finished word while the receiver stalls, and
// the next input word is accepted meanwhile; a second query waits only if
// the previous result has not been taken.
// Reset (synchronous, active low) empties the store, clears the overflow
// flag and drops any pending output word.
module point_in_polygon_test_top import pip_pkg::*; #(
    parameter int MAX_VERTICES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
